[rtl/elg_pkg.sv]
// elg_pkg: shared types and constants for the escalation ladder gate.
// Function codes, rung constants and the controller/datapath link structs.
// No dependencies.
`timescale 1ns / 1ps

package elg_pkg;

  localparam int RUNG_WIDTH = 2;
  localparam int FUNC_WIDTH = 2;

  typedef logic [RUNG_WIDTH-1:0] rung_t;
  typedef logic [FUNC_WIDTH-1:0] func_t;

  localparam func_t FUNC_DECIDE  = 2'd0;
  localparam func_t FUNC_RESET   = 2'd1;
  localparam func_t FUNC_RESOLVE = 2'd2;

  localparam rung_t RUNG_TOP = 2'd3;

  // Controller -> datapath commands, all single-cycle strobes.
  typedef struct packed {
    logic load_result;
    logic escalate;
    logic clear_episode;
    logic resolve;
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic may_escalate;
  } sts_t;

endpackage

[rtl/elg_in_if.sv]
// elg_in_if: valid/ready channel carrying one request transaction.
// Depends on elg_pkg for the field types.
`timescale 1ns / 1ps

interface elg_in_if #(
  parameter int COUNT_WIDTH = 16
);
  import elg_pkg::*;

  logic                   valid;
  logic                   ready;
  func_t                  func;
  logic                   deficit_flag;
  logic [COUNT_WIDTH-1:0] blocked_agents;
  rung_t                  current_rung;

  modport source (output valid, func, deficit_flag, blocked_agents, current_rung,
                  input ready);
  modport sink   (input valid, func, deficit_flag, blocked_agents, current_rung,
                  output ready);
endinterface

[rtl/elg_out_if.sv]
// elg_out_if: valid/ready channel carrying one decision transaction.
// Depends on elg_pkg for the field types.
`timescale 1ns / 1ps

interface elg_out_if;
  import elg_pkg::*;

  logic  valid;
  logic  ready;
  rung_t new_rung;
  logic  escalated;

  modport source (output valid, new_rung, escalated, input ready);
  modport sink   (input valid, new_rung, escalated, output ready);
endinterface

[rtl/elg_ctrl.sv]
// elg_ctrl: handshake controller for the escalation ladder gate.
// Decodes accepted transactions into datapath commands; owns result valid.
// Depends on elg_pkg.
`timescale 1ns / 1ps

module elg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  elg_pkg::func_t func,
  output logic           out_valid,
  input  logic           out_ready,
  input  elg_pkg::sts_t  sts,
  output elg_pkg::cmd_t  cmd
);
  import elg_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_FULL
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready  = (state == S_EMPTY) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == S_FULL);

  always_comb begin
    cmd = '0;
    if (accept) begin
      case (func)
        FUNC_DECIDE: begin
          cmd.load_result = 1'b1;
          cmd.escalate    = sts.may_escalate;
        end
        FUNC_RESET:   cmd.clear_episode = 1'b1;
        FUNC_RESOLVE: cmd.resolve       = 1'b1;
        default:      ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    if (cmd.load_result) begin
      state_next = S_FULL;
    end else if (out_ready) begin
      state_next = S_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/elg_dpath.sv]
// elg_dpath: episode bookkeeping and result register of the ladder gate.
// Holds signature store, escalation count, pending flag; compares in parallel.
// Depends on elg_pkg; driven by elg_ctrl commands.
`timescale 1ns / 1ps

module elg_dpath #(
  parameter int COUNT_WIDTH     = 16,
  parameter int MAX_ESCALATIONS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  elg_pkg::cmd_t          cmd,
  output elg_pkg::sts_t          sts,
  input  logic                   deficit_flag,
  input  logic [COUNT_WIDTH-1:0] blocked_agents,
  input  elg_pkg::rung_t         current_rung,
  output elg_pkg::rung_t         new_rung,
  output logic                   escalated
);
  import elg_pkg::*;

  localparam int SIG_WIDTH = COUNT_WIDTH + 1;
  localparam int CNT_WIDTH = $clog2(MAX_ESCALATIONS + 1);
  localparam int IDX_WIDTH = (MAX_ESCALATIONS > 1) ? $clog2(MAX_ESCALATIONS) : 1;
  localparam logic [CNT_WIDTH-1:0] CNT_LIMIT = CNT_WIDTH'(MAX_ESCALATIONS);

  logic [SIG_WIDTH-1:0] sig_store [MAX_ESCALATIONS];
  logic [CNT_WIDTH-1:0] esc_count;
  logic                 pending;

  logic [SIG_WIDTH-1:0]       sig;
  logic [MAX_ESCALATIONS-1:0] hit;
  logic                       seen;
  logic                       trigger;
  logic                       at_limit;
  rung_t                      rung_up;

  assign sig     = {blocked_agents, deficit_flag};
  assign trigger = deficit_flag || (blocked_agents != '0);
  assign at_limit = (esc_count >= CNT_LIMIT);

  // Entry i is live only once escalation number i has written it.
  always_comb begin
    for (int i = 0; i < MAX_ESCALATIONS; i++) begin
      hit[i] = (CNT_WIDTH'(i) < esc_count) && (sig_store[i] == sig);
    end
  end

  assign seen = |hit;
  assign sts.may_escalate = trigger && !pending && !seen && !at_limit;
  assign rung_up = (current_rung == RUNG_TOP) ? RUNG_TOP : current_rung + rung_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_count <= '0;
      pending   <= 1'b0;
    end else begin
      if (cmd.clear_episode) begin
        esc_count <= '0;
        pending   <= 1'b0;
      end else if (cmd.resolve) begin
        pending <= 1'b0;
      end else if (cmd.escalate) begin
        esc_count <= esc_count + CNT_WIDTH'(1);
        pending   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.escalate) begin
      sig_store[esc_count[IDX_WIDTH-1:0]] <= sig;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      new_rung  <= cmd.escalate ? rung_up : current_rung;
      escalated <= cmd.escalate;
    end
  end

endmodule

[rtl/escalation_ladder_gate.sv]
// escalation_ladder_gate: top level of the recovery ladder escalation gate.
// Joins elg_ctrl and elg_dpath; channels use elg_in_if and elg_out_if.
//
// Usage:
//   cmd carries one transaction per item: func (decide, reset episode,
//   resolve), deficit_flag, blocked_agents and current_rung.
//   res carries one decision (new_rung, escalated) per accepted decide
//   transaction; reset-episode, resolve and the unused code give none.
//   A decide's result is registered on acceptance and shows on res from the
//   cycle after it. One transaction is taken per cycle while cmd.ready is
//   high; signature compares, count and pending update settle on acceptance.
//   A single output register parts the channels: cmd.ready stays high while
//   that register is empty or being taken, so a stalled receiver holds the
//   result and backs up cmd only while the register is full.
//   Reset (rst, synchronous) empties the output register and clears the
//   escalation count and pending flag; stored signatures need no clearing
//   since an entry is only compared once the count covers it.
`timescale 1ns / 1ps

module escalation_ladder_gate #(
  parameter int COUNT_WIDTH     = 16,
  parameter int MAX_ESCALATIONS = 3
) (
  input logic      clk,
  input logic      rst,
  elg_in_if.sink   cmd,
  elg_out_if.source res
);
  import elg_pkg::*;

  cmd_t link_cmd;
  sts_t link_sts;

  elg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .func      (cmd.func),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (link_sts),
    .cmd       (link_cmd)
  );

  elg_dpath #(
    .COUNT_WIDTH     (COUNT_WIDTH),
    .MAX_ESCALATIONS (MAX_ESCALATIONS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (link_cmd),
    .sts            (link_sts),
    .deficit_flag   (cmd.deficit_flag),
    .blocked_agents (cmd.blocked_agents),
    .current_rung   (cmd.current_rung),
    .new_rung       (res.new_rung),
    .escalated      (res.escalated)
  );

endmodule

[rtl/elg_checker.sv]
// elg_checker: port-level assertions for escalation_ladder_gate, plus its bind.
// Depends on elg_pkg.
`timescale 1ns / 1ps

module elg_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input elg_pkg::func_t func,
  input logic           out_valid,
  input logic           out_ready,
  input elg_pkg::rung_t new_rung,
  input logic           escalated
);
  import elg_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled decision holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_rung) && $stable(escalated))
    else $error("stalled decision changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_decide_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && func == FUNC_DECIDE |=> out_valid)
    else $error("decide transaction gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_acc && func != FUNC_DECIDE && (!out_valid || out_ready) |=> !out_valid)
    else $error("result without decide transaction");

  a_escalated_rung: assert property (@(posedge clk) disable iff (rst)
    out_valid && escalated |-> new_rung != '0)
    else $error("escalation reported at lowest rung");

endmodule

bind escalation_ladder_gate elg_checker u_elg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .func      (cmd.func),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .new_rung  (res.new_rung),
  .escalated (res.escalated)
);

[tb/sv/testbench.sv]
// testbench: self-checking bench for escalation_ladder_gate, driving decide, reset-episode,
// resolve and unused-code transactions with a built-in ladder predictor and a result checker.
// Depends on elg_pkg, elg_in_if, elg_out_if and the escalation_ladder_gate RTL.
`timescale 1ns / 1ps

module testbench;
  import elg_pkg::*;

  localparam int  COUNT_W      = 16;
  localparam int  MAX_ESC      = 3;
  localparam int  LIMIT_CYCLES = 200000;
  localparam int  RANDOM_ITEMS = 150;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [COUNT_W:0]   sig_t;

  typedef struct {
    rung_t new_rung;
    logic  escalated;
  } decision_t;

  logic clk;
  logic rst;

  elg_in_if #(.COUNT_WIDTH(COUNT_W)) cmd ();
  elg_out_if res ();

  escalation_ladder_gate #(
    .COUNT_WIDTH    (COUNT_W),
    .MAX_ESCALATIONS(MAX_ESC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  // Ladder state as the predictor sees it
  sig_t        escalated_sigs [MAX_ESC];
  int unsigned escalation_count = 0;
  bit          action_pending   = 0;
  decision_t   pending_decisions [$];

  int errors         = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Per-episode pool of signatures so repeats actually happen
  sig_t sig_pool [6];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_decisions
    decision_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("unexpected decision: new_rung=%0d escalated=%0d", res.new_rung, res.escalated);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (res.new_rung !== want.new_rung) begin
          $error("new_rung: expected %0d, got %0d", want.new_rung, res.new_rung);
          errors++;
        end
        if (res.escalated !== want.escalated) begin
          $error("escalated: expected %0d, got %0d", want.escalated, res.escalated);
          errors++;
        end
      end
    end
  end

  // Advance the predicted ladder by one accepted transaction
  task automatic apply_to_ladder(func_t f, logic ov, count_t bc, rung_t r);
    sig_t      sig;
    bit        seen;
    decision_t d;
    int        i;
    case (f)
      FUNC_RESET: begin
        escalation_count = 0;
        action_pending   = 0;
      end
      FUNC_RESOLVE: begin
        action_pending = 0;
      end
      FUNC_DECIDE: begin
        d.new_rung  = r;
        d.escalated = 1'b0;
        sig  = {bc, ov};
        seen = 0;
        for (i = 0; i < escalation_count; i++)
          if (escalated_sigs[i] == sig) seen = 1;
        if ((ov || bc != '0) && !action_pending && !seen && escalation_count < MAX_ESC) begin
          escalated_sigs[escalation_count] = sig;
          escalation_count++;
          action_pending = 1;
          d.new_rung  = (r == RUNG_TOP) ? RUNG_TOP : rung_t'(r + 1);
          d.escalated = 1'b1;
        end
        pending_decisions.push_back(d);
      end
      default: ;
    endcase
  endtask

  // Send one transaction; valid stays high afterwards until the caller drops it
  task automatic send_cmd(func_t f, logic ov, count_t bc, rung_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid          <= 1'b1;
    cmd.func           <= f;
    cmd.deficit_flag   <= ov;
    cmd.blocked_agents <= bc;
    cmd.current_rung   <= r;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    apply_to_ladder(f, ov, bc, r);
  endtask

  task automatic wait_all_decisions();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending_decisions.size() != 0);
  endtask

  task automatic set_traffic(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic count_t pick_count();
    case ($urandom_range(3))
      0:       return count_t'($urandom_range(3));
      1:       return '1;
      default: return count_t'($urandom);
    endcase
  endfunction

  task automatic refill_sig_pool();
    int i;
    for (i = 0; i < 6; i++)
      sig_pool[i] = {pick_count(), 1'($urandom_range(1))};
  endtask

  task automatic test_no_trigger();
    int r;
    for (r = 0; r < 4; r++)
      send_cmd(FUNC_DECIDE, 1'b0, '0, rung_t'(r));
  endtask

  task automatic test_climb_and_limits();
    send_cmd(FUNC_RESET,   1'b0, '0,         rung_t'(0));
    send_cmd(FUNC_DECIDE,  1'b1, '1,         RUNG_TOP);   // escalates, rung stays at top
    send_cmd(FUNC_DECIDE,  1'b0, count_t'(1), rung_t'(0)); // held by pending action
    send_cmd(FUNC_RESOLVE, 1'b0, '0,         rung_t'(0));
    send_cmd(FUNC_DECIDE,  1'b1, '1,         rung_t'(1)); // repeat signature
    send_cmd(FUNC_DECIDE,  1'b0, count_t'(1), rung_t'(0));
    send_cmd(FUNC_RESOLVE, 1'b0, '0,         rung_t'(0));
    send_cmd(FUNC_DECIDE,  1'b1, '0,         rung_t'(2));
    send_cmd(FUNC_RESOLVE, 1'b0, '0,         rung_t'(0));
    send_cmd(FUNC_DECIDE,  1'b0, count_t'(16'h8000), rung_t'(1)); // escalation limit
    send_cmd(func_t'(3),   1'b1, '1,         RUNG_TOP);   // unused code, ignored
    send_cmd(FUNC_DECIDE,  1'b0, '0,         RUNG_TOP);
    send_cmd(FUNC_RESET,   1'b1, '1,         RUNG_TOP);
    send_cmd(FUNC_DECIDE,  1'b1, '1,         rung_t'(2)); // old signature counts again
  endtask

  task automatic test_drain_pause();
    send_cmd(FUNC_DECIDE, 1'b1, count_t'($urandom), rung_t'($urandom_range(3)));
    send_cmd(FUNC_DECIDE, 1'b0, count_t'($urandom), rung_t'($urandom_range(3)));
    wait_all_decisions();
    send_cmd(FUNC_RESOLVE, 1'b0, '0, rung_t'(0));
  endtask

  // Mostly well-formed episodes drawn from a small signature pool, with some noise
  task automatic run_random_ladder(int n_items);
    int    sent;
    int    pick;
    sig_t  sig;
    func_t f;
    sent = 0;
    refill_sig_pool();
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        f = func_t'($urandom_range(3));
        send_cmd(f, 1'($urandom_range(1)), count_t'($urandom), rung_t'($urandom_range(3)));
        if (f != func_t'(3)) sent++;
      end else if (pick < 16) begin
        send_cmd(FUNC_RESET, 1'($urandom_range(1)), pick_count(), rung_t'($urandom_range(3)));
        refill_sig_pool();
        sent++;
      end else if (pick < 36) begin
        send_cmd(FUNC_RESOLVE, 1'($urandom_range(1)), pick_count(), rung_t'($urandom_range(3)));
        sent++;
      end else begin
        if ($urandom_range(99) < 70)
          sig = sig_pool[$urandom_range(5)];
        else
          sig = {pick_count(), 1'($urandom_range(1))};
        send_cmd(FUNC_DECIDE, sig[0], sig[COUNT_W:1], rung_t'($urandom_range(3)));
        sent++;
      end
      if ($urandom_range(99) == 0) wait_all_decisions();
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cmd.valid          <= 1'b0;
    cmd.func           <= FUNC_DECIDE;
    cmd.deficit_flag   <= 1'b0;
    cmd.blocked_agents <= '0;
    cmd.current_rung   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_traffic(0, 0);
    test_no_trigger();
    test_climb_and_limits();
    test_drain_pause();
    run_random_ladder(RANDOM_ITEMS);
    set_traffic(65, 0);
    run_random_ladder(RANDOM_ITEMS);
    set_traffic(0, 65);
    run_random_ladder(RANDOM_ITEMS);
    set_traffic(11, 11);
    run_random_ladder(RANDOM_ITEMS);

    wait_all_decisions();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
